// ===== hdl/tvp_pkg.sv =====
// Package for the trapezoid velocity profile planner.
// Shared widths, constants, the front-to-back item record and the result record. No dependencies.
package tvp_pkg;

  localparam int unsigned RateBits = 24;
  localparam int unsigned StepBits = 32;
  localparam int unsigned FactBits = 17;
  localparam int unsigned DeltaBits = 32;
  localparam int unsigned TicksBits = 16;
  localparam int unsigned AccBits = 56;   // delta * ticks * 60 < 2^54
  localparam int unsigned AccHalf = AccBits / 2;
  localparam int unsigned SqBits = 2 * RateBits;
  localparam int unsigned NumBits = 112;  // dividend width
  localparam int unsigned DivBits = 59;   // 4 * accel
  localparam logic [FactBits-1:0] OneQ16 = FactBits'(65536);
  localparam logic [TicksBits-1:0] TicksReset = TicksBits'(1000);
  localparam logic [63:0] DistCap = 64'h0000_0100_0000_0000;

  typedef struct packed {
    logic [RateBits-1:0] rate;
    logic [FactBits-1:0] entry;
    logic [FactBits-1:0] exit_f;
    logic [DeltaBits-1:0] delta;
    logic [StepBits-1:0] total;
    logic [StepBits-1:0] remain;
    logic [TicksBits-1:0] ticks;
  } item_t;

  typedef struct packed {
    logic [RateBits-1:0] ri;
    logic [RateBits-1:0] rf;
    logic [StepBits-1:0] acc_end;
    logic [StepBits-1:0] dec_start;
    logic err;
  } res_t;

endpackage

// ===== hdl/tvp_front.sv =====
// Front part: accepts input beats and queues items in a two-entry queue.
// Depends on tvp_pkg.
module tvp_front import tvp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push,
  output logic         full,
  input  item_t        item_i,
  output logic         valid_o,
  input  logic         take_i,
  output item_t        item_o
);
  item_t     mem_q [2];
  logic      wp_q, rp_q;
  logic [1:0] cnt_q;
  logic      wr, rd;

  assign full    = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign wr      = push && !full;
  assign rd      = take_i && valid_o;
  assign item_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end
endmodule

// ===== hdl/tvp_div.sv =====
// Restoring divider, one quotient bit per cycle, with saturation at 2^40.
// Depends on tvp_pkg.
module tvp_div import tvp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [NumBits-1:0] num_i,
  input  logic [DivBits-1:0] den_i,
  input  logic               up_i,
  output logic               done_o,
  output logic [63:0]        quo_o
);
  logic [NumBits-1:0] n_q, q_q;
  logic [DivBits:0]   r_q;
  logic [DivBits-1:0] d_q;
  logic [6:0]         k_q;
  logic               busy_q, up_q;
  logic [DivBits:0]   sh;
  logic               ge;

  assign sh = {r_q[DivBits-1:0], n_q[NumBits-1]};
  assign ge = sh >= {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_o <= 1'b0; k_q <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1; k_q <= 7'(NumBits - 1);
      end else if (busy_q) begin
        if (k_q == 7'd0) begin
          busy_q <= 1'b0; done_o <= 1'b1;
        end
        k_q <= k_q - 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q <= num_i; d_q <= den_i; up_q <= up_i; r_q <= '0; q_q <= '0;
    end else if (busy_q) begin
      n_q <= n_q << 1;
      r_q <= ge ? sh - {1'b0, d_q} : sh;
      q_q <= {q_q[NumBits-2:0], ge};
    end
  end

  always_comb begin
    if (q_q[NumBits-1:40] != '0) quo_o = DistCap;
    else quo_o = 64'(q_q[39:0]) + 64'(up_q && (r_q != '0));
  end
endmodule

// ===== hdl/tvp_back.sv =====
// Back part: sequencer computing rates, distances and step indices per item.
// Depends on tvp_pkg and tvp_div.
module tvp_back import tvp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  take_o,
  input  item_t item_i,
  output logic  res_valid_o,
  input  logic  res_take_i,
  output res_t  res_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_ACC1, S_ACC2, S_RATE, S_SQ, S_DIVA, S_WAITA, S_DIVD, S_WAITD,
    S_CHK, S_MUL, S_DIVX, S_WAITX, S_OUT
  } state_e;

  state_e state_q;
  item_t  it_q;
  logic [AccBits-1:0] acc_q;
  logic [RateBits-1:0] ri_q, rf_q;
  logic [SqBits-1:0] nn_q, ii_q, ff_q;
  logic [63:0] a_q, d_q, plat_q;
  logic [NumBits-1:0] pos_q;
  res_t res_q;
  logic outv_q;

  logic [FactBits-1:0] fsel;
  logic [RateBits+FactBits-1:0] prod;
  logic div_start, div_up, div_done;
  logic [NumBits-1:0] div_num;
  logic [DivBits-1:0] div_den;
  logic [63:0] quo;
  logic [64:0] ad;
  logic [63:0] base, acl;
  logic out_ld;

  assign take_o = (state_q == S_IDLE);
  assign out_ld = (state_q == S_OUT) && (!outv_q || res_take_i);
  assign res_valid_o = outv_q;
  assign res_o = res_q;

  always_comb begin
    fsel = (ri_q == '0 && state_q == S_RATE) ? it_q.entry : it_q.exit_f;
    if (fsel > OneQ16) fsel = OneQ16;
    prod = (RateBits+FactBits)'(fsel) * (RateBits+FactBits)'(it_q.rate);
  end

  tvp_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .up_i(div_up), .done_o(div_done), .quo_o(quo)
  );

  always_comb begin
    div_start = 1'b0; div_up = 1'b0;
    div_num = '0; div_den = DivBits'({acc_q, 1'b0});
    case (state_q)
      S_DIVA: begin
        div_start = 1'b1; div_up = 1'b1;
        div_num = NumBits'({nn_q - ii_q, 16'h0000});
      end
      S_DIVD: begin
        div_start = 1'b1;
        div_num = NumBits'({nn_q - ff_q, 16'h0000});
      end
      S_DIVX: begin
        div_start = 1'b1; div_up = 1'b1;
        div_num = pos_q - NumBits'({ii_q, 16'h0000});
        div_den = DivBits'({acc_q, 2'b00});
      end
      default: ;
    endcase
  end

  assign ad = 65'(a_q) + 65'(d_q);
  assign base = (it_q.remain < it_q.total) ? 64'(it_q.total - it_q.remain) : 64'd0;
  assign acl = (quo > 64'(it_q.remain)) ? 64'(it_q.remain) : quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      outv_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: if (valid_i) state_q <= S_ACC1;
        S_ACC1: state_q <= S_ACC2;
        S_ACC2: state_q <= (acc_q == '0) ? S_OUT : S_RATE;
        S_RATE: state_q <= S_SQ;
        S_SQ:   state_q <= S_DIVA;
        S_DIVA: state_q <= S_WAITA;
        S_WAITA: if (div_done) state_q <= S_DIVD;
        S_DIVD: state_q <= S_WAITD;
        S_WAITD: if (div_done) state_q <= S_CHK;
        S_CHK:  state_q <= (ad <= 65'(it_q.remain)) ? S_OUT : S_MUL;
        S_MUL:  state_q <= (pos_q > NumBits'({ii_q, 16'h0000})) ? S_DIVX : S_OUT;
        S_DIVX: state_q <= S_WAITX;
        S_WAITX: if (div_done) state_q <= S_OUT;
        S_OUT:  if (out_ld) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
      if (out_ld) outv_q <= 1'b1;
      else if (res_take_i) outv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: if (valid_i) begin
        it_q <= item_i; ri_q <= '0; rf_q <= '0;
      end
      S_ACC1: acc_q <= AccBits'(it_q.delta * it_q.ticks);
      S_ACC2: acc_q <= AccBits'(acc_q * 7'd60);
      S_RATE: begin
        ri_q <= RateBits'((prod + (RateBits+FactBits)'(16'hFFFF)) >> 16);
        nn_q <= it_q.rate * it_q.rate;
      end
      S_SQ: begin
        rf_q <= RateBits'((prod + (RateBits+FactBits)'(16'hFFFF)) >> 16);
        ii_q <= ri_q * ri_q;
      end
      S_DIVA: begin
        ff_q <= rf_q * rf_q;
        pos_q <= NumBits'(acc_q[AccHalf-1:0] * it_q.remain);
      end
      S_DIVD: pos_q <= pos_q + (NumBits'(acc_q[AccBits-1:AccHalf] * it_q.remain) << AccHalf);
      S_WAITA: if (div_done) a_q <= quo;
      S_WAITD: if (div_done) d_q <= quo;
      S_CHK: begin
        plat_q <= 64'(it_q.remain) - a_q - d_q;
        pos_q <= (pos_q << 1) + NumBits'({ff_q, 16'h0000});
      end
      S_MUL: begin
        plat_q <= '0;
        a_q <= '0;
      end
      S_WAITX: if (div_done) a_q <= acl;
      S_OUT: if (out_ld) begin
        if (acc_q == '0) res_q <= '{err: 1'b1, default: '0};
        else begin
          res_q.ri <= ri_q; res_q.rf <= rf_q; res_q.err <= 1'b0;
          res_q.acc_end <= StepBits'(base + a_q);
          res_q.dec_start <= StepBits'(base + a_q + plat_q);
        end
      end
      default: ;
    endcase
  end
endmodule

// ===== hdl/trapezoid_velocity_profile_top.sv =====
// Top level of the trapezoid velocity profile planner.
// Depends on tvp_pkg, tvp_front, tvp_back, tvp_div.
//
// An item takes two passes of the shared one-bit-per-cycle divider when both
// distances fit in the remaining steps, two or three on the intersection path
// and none for a zero acceleration; each pass yields a 112-bit quotient. A
// two-entry input queue lets new items enter while one is computed, and a
// result register holds the finished result until popped while the next item
// is computed; the back part stalls only when a new result is ready and that
// register is still occupied.
module trapezoid_velocity_profile_top import tvp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic [RateBits-1:0]  nominal_rate_i,
  input  logic [FactBits-1:0]  entry_factor_i,
  input  logic [FactBits-1:0]  exit_factor_i,
  input  logic [DeltaBits-1:0] rate_delta_i,
  input  logic [StepBits-1:0]  steps_total_i,
  input  logic [StepBits-1:0]  steps_remaining_i,
  input  logic                 cfg_we_i,
  input  logic [TicksBits-1:0] cfg_wdata_i,
  output logic                 empty,
  input  logic                 pop,
  output logic [RateBits-1:0]  start_rate_o,
  output logic [RateBits-1:0]  end_rate_o,
  output logic [StepBits-1:0]  accel_end_o,
  output logic [StepBits-1:0]  decel_start_o,
  output logic                 accel_error_o
);
  logic [TicksBits-1:0] ticks_q;
  item_t in_item, q_item;
  logic q_valid, q_take, r_valid;
  res_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ticks_q <= TicksReset;
    else if (cfg_we_i) ticks_q <= cfg_wdata_i;
  end

  assign in_item = '{rate: nominal_rate_i, entry: entry_factor_i,
                     exit_f: exit_factor_i, delta: rate_delta_i,
                     total: steps_total_i, remain: steps_remaining_i,
                     ticks: ticks_q};

  tvp_front u_front (
    .clk_i, .rst_ni, .push, .full, .item_i(in_item),
    .valid_o(q_valid), .take_i(q_take), .item_o(q_item)
  );

  tvp_back u_back (
    .clk_i, .rst_ni, .valid_i(q_valid), .take_o(q_take), .item_i(q_item),
    .res_valid_o(r_valid), .res_take_i(pop), .res_o(res)
  );

  assign empty = !r_valid;
  assign start_rate_o = res.ri;
  assign end_rate_o = res.rf;
  assign accel_end_o = res.acc_end;
  assign decel_start_o = res.dec_start;
  assign accel_error_o = res.err;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && accel_error_o) |-> (start_rate_o == '0 && end_rate_o == '0))
    else $error("error result carries rates");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(accel_end_o)))
    else $error("result changed while waiting");
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !accel_error_o) |-> (decel_start_o >= accel_end_o))
    else $error("deceleration before acceleration end");
endmodule

// ===== sim/tb_trapezoid_velocity_profile_top.sv =====
// Testbench for trapezoid_velocity_profile_top: directed and random motion blocks
// are checked against a built-in profile predictor under several idling phases.
// Depends on tvp_pkg and the planner RTL.
module tb_trapezoid_velocity_profile_top;
  import tvp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchLimit = 20000;
  localparam int unsigned DrainCycles = 450;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [RateBits-1:0] nominal_rate_i = '0;
  logic [FactBits-1:0] entry_factor_i = '0;
  logic [FactBits-1:0] exit_factor_i = '0;
  logic [DeltaBits-1:0] rate_delta_i = '0;
  logic [StepBits-1:0] steps_total_i = '0;
  logic [StepBits-1:0] steps_remaining_i = '0;
  logic cfg_we_i = 1'b0;
  logic [TicksBits-1:0] cfg_wdata_i = '0;
  logic empty;
  logic pop = 1'b0;
  logic [RateBits-1:0] start_rate_o;
  logic [RateBits-1:0] end_rate_o;
  logic [StepBits-1:0] accel_end_o;
  logic [StepBits-1:0] decel_start_o;
  logic accel_error_o;

  trapezoid_velocity_profile_top u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full),
    .nominal_rate_i(nominal_rate_i), .entry_factor_i(entry_factor_i),
    .exit_factor_i(exit_factor_i), .rate_delta_i(rate_delta_i),
    .steps_total_i(steps_total_i), .steps_remaining_i(steps_remaining_i),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i), .empty(empty), .pop(pop),
    .start_rate_o(start_rate_o), .end_rate_o(end_rate_o),
    .accel_end_o(accel_end_o), .decel_start_o(decel_start_o),
    .accel_error_o(accel_error_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  logic [TicksBits-1:0] ticks_model = TicksReset;
  res_t profile_q[$];
  int unsigned send_idle_pct = 0;
  int unsigned pop_stall_pct = 0;
  int unsigned quiet_cycles = 0;
  bit failed = 1'b0;

  function automatic logic [63:0] dist_div(logic [127:0] num, logic [63:0] den, bit up);
    logic [127:0] quo;
    logic [127:0] rmd;
    quo = num / den;
    rmd = num % den;
    if (quo >= DistCap) return DistCap;
    return quo[63:0] + ((up && rmd != 0) ? 64'd1 : 64'd0);
  endfunction

  function automatic logic [63:0] scale_rate(logic [FactBits-1:0] fac, logic [RateBits-1:0] rate);
    logic [63:0] f;
    f = (fac > OneQ16) ? 64'(OneQ16) : 64'(fac);
    return (f * 64'(rate) + 64'd65535) >> 16;
  endfunction

  function automatic res_t predict_profile(item_t it);
    res_t r;
    logic [63:0] accel, ri, rf, acc, dec, plat, rsq, rem, tot, up_end, down_start;
    logic [127:0] pos, neg;
    accel = 64'(it.delta) * 64'(ticks_model) * 64'd60;
    r = '0;
    if (accel == 0) begin
      r.err = 1'b1;
      return r;
    end
    ri = scale_rate(it.entry, it.rate);
    rf = scale_rate(it.exit_f, it.rate);
    rsq = 64'(it.rate) * 64'(it.rate);
    rem = 64'(it.remain);
    tot = 64'(it.total);
    acc = dist_div(128'(rsq - ri * ri) << 16, 2 * accel, 1'b1);
    dec = dist_div(128'(rsq - rf * rf) << 16, 2 * accel, 1'b0);
    if (acc + dec <= rem) begin
      plat = rem - acc - dec;
    end else begin
      pos = 128'(2 * accel) * 128'(rem) + (128'(rf * rf) << 16);
      neg = 128'(ri * ri) << 16;
      if (pos > neg) begin
        acc = dist_div(pos - neg, 4 * accel, 1'b1);
        if (acc > rem) acc = rem;
      end else begin
        acc = 0;
      end
      plat = 0;
    end
    up_end = (rem < tot) ? tot - rem + acc : acc;
    down_start = up_end + plat;
    r.ri = ri[RateBits-1:0];
    r.rf = rf[RateBits-1:0];
    r.acc_end = up_end[StepBits-1:0];
    r.dec_start = down_start[StepBits-1:0];
    return r;
  endfunction

  task automatic send_block(item_t it);
    if (send_idle_pct != 0) begin
      while ($urandom_range(99) < send_idle_pct) begin
        push <= 1'b0;
        @(posedge clk_i);
      end
    end
    push <= 1'b1;
    nominal_rate_i <= it.rate;
    entry_factor_i <= it.entry;
    exit_factor_i <= it.exit_f;
    rate_delta_i <= it.delta;
    steps_total_i <= it.total;
    steps_remaining_i <= it.remain;
    do @(posedge clk_i); while (full);
    profile_q.push_back(predict_profile(it));
    quiet_cycles = 0;
  endtask

  task automatic write_ticks(logic [TicksBits-1:0] v);
    push <= 1'b0;
    while (profile_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ticks_model = v;
  endtask

  function automatic item_t mk_block(logic [23:0] rate, logic [16:0] en, logic [16:0] ex,
                                     logic [31:0] dl, logic [31:0] tot, logic [31:0] rem);
    item_t it;
    it = '0;
    it.rate = rate; it.entry = en; it.exit_f = ex;
    it.delta = dl; it.total = tot; it.remain = rem;
    return it;
  endfunction

  function automatic item_t rand_block();
    item_t it;
    it = '0;
    it.rate = RateBits'($urandom() >> $urandom_range(31, 8));
    it.entry = ($urandom_range(9) < 8) ? 17'($urandom_range(65536)) : 17'($urandom());
    it.exit_f = ($urandom_range(9) < 8) ? 17'($urandom_range(65536)) : 17'($urandom());
    it.delta = $urandom() >> $urandom_range(31);
    it.total = $urandom() >> $urandom_range(31);
    it.remain = ($urandom_range(3) != 0) ? $urandom_range(it.total) : $urandom();
    return it;
  endfunction

  task automatic test_directed();
    send_block(mk_block(24'd0, 17'd0, 17'd0, 32'h10000, 32'd100, 32'd100));
    send_block(mk_block(24'hFFFFFF, 17'd0, 17'd0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
    send_block(mk_block(24'd6000, 17'd65536, 17'd65536, 32'h10000, 32'd500, 32'd500));
    send_block(mk_block(24'd6000, 17'h1FFFF, 17'h10001, 32'h10000, 32'd500, 32'd500));
    send_block(mk_block(24'd6000, 17'd32768, 17'd16384, 32'd0, 32'd500, 32'd200));
    send_block(mk_block(24'hFFFFFF, 17'd1, 17'd1, 32'd1, 32'd1000, 32'd1000));
    send_block(mk_block(24'hFFFFFF, 17'd0, 17'd65535, 32'd1, 32'hFFFFFFFF, 32'd7));
    send_block(mk_block(24'd12000, 17'd0, 17'd0, 32'h8000, 32'd50, 32'd20));
    send_block(mk_block(24'd12000, 17'd0, 17'd0, 32'h8000, 32'd20, 32'd50));
    send_block(mk_block(24'd12000, 17'd40000, 17'd0, 32'h8000, 32'd0, 32'd0));
    send_block(mk_block(24'd1, 17'd1, 17'd1, 32'h1, 32'd3, 32'd3));
    send_block(mk_block(24'd300000, 17'd0, 17'd65536, 32'h200000, 32'd4000, 32'd1500));
    send_block(mk_block(24'd300000, 17'd65536, 17'd0, 32'h200000, 32'd40, 32'd40));
    send_block(mk_block(24'h800000, 17'd20000, 17'd50000, 32'h80000000, 32'h80000000,
                        32'h7FFFFFFF));
  endtask

  task automatic test_random(int unsigned n, logic [TicksBits-1:0] ticks,
                             int unsigned idle, int unsigned stall);
    if (ticks != ticks_model) write_ticks(ticks);
    send_idle_pct = idle;
    pop_stall_pct = stall;
    repeat (n) send_block(rand_block());
  endtask

  task automatic test_zero_ticks();
    write_ticks('0);
    send_block(mk_block(24'd6000, 17'd0, 17'd0, 32'hFFFFFFFF, 32'd10, 32'd10));
    send_block(rand_block());
  endtask

  always @(posedge clk_i) begin
    if (pop && !empty) begin
      if (profile_q.size() == 0) begin
        $error("unexpected result beat");
        failed = 1'b1;
      end else begin
        automatic res_t e = profile_q.pop_front();
        quiet_cycles = 0;
        if (start_rate_o !== e.ri) begin
          $error("start_rate exp %0d got %0d", e.ri, start_rate_o); failed = 1'b1;
        end
        if (end_rate_o !== e.rf) begin
          $error("end_rate exp %0d got %0d", e.rf, end_rate_o); failed = 1'b1;
        end
        if (accel_end_o !== e.acc_end) begin
          $error("accel_end exp %0d got %0d", e.acc_end, accel_end_o);
          failed = 1'b1;
        end
        if (decel_start_o !== e.dec_start) begin
          $error("decel_start exp %0d got %0d", e.dec_start, decel_start_o);
          failed = 1'b1;
        end
        if (accel_error_o !== e.err) begin
          $error("accel_error exp %0d got %0d", e.err, accel_error_o); failed = 1'b1;
        end
      end
    end
    pop <= !(pop_stall_pct != 0 && $urandom_range(99) < pop_stall_pct);
  end

  always @(posedge clk_i) begin
    quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(475, TicksReset, 0, 0);
    test_random(475, 16'hFFFF, 87, 0);
    test_zero_ticks();
    test_random(475, 16'd1, 0, 87);
    test_random(475, 16'($urandom_range(65535, 1)), 20, 20);
    push <= 1'b0;
    while (profile_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (!failed) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
